// File: rtl/core/whi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// whi_pkg - weighted integral histogram shared definitions
// Register codes, configuration and result types shared by the front end,
// the back end and the top level.
// ============================================================================
package whi_pkg;

   localparam int VAL_W       = 36;
   localparam int BIN_IN_W    = 4;
   localparam int WEIGHT_W    = 16;
   localparam int BIN_OUT_W   = 4;
   localparam int POS_OUT_W   = 10;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;

   localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

   localparam logic [10:0] RST_ACTIVE_WIDTH  = 11'd1024;
   localparam logic [10:0] RST_ACTIVE_HEIGHT = 11'd1024;
   localparam logic [4:0]  RST_NUM_BINS      = 5'd16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ACTIVE_WIDTH  = 2'd0,
      CSR_ACTIVE_HEIGHT = 2'd1,
      CSR_NUM_BINS      = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [10:0] active_width;
      logic [10:0] active_height;
      logic [4:0]  num_bins;
   } cfg_type;

   typedef struct packed {
      logic [BIN_OUT_W-1:0] bin;
      logic [VAL_W-1:0]     integral_value;
      logic [POS_OUT_W-1:0] column;
      logic [POS_OUT_W-1:0] row;
      logic                 last_bin;
      logic                 bad_bin;
   } rsp_item_type;

   typedef enum logic [1:0] {
      BACK_CLEAR = 2'd0,
      BACK_IDLE  = 2'd1,
      BACK_ISSUE = 2'd2
   } back_state_type;

endpackage
`default_nettype wire

// File: rtl/core/whi_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// whi_fifo - small transaction queue
// Register-based FIFO with occupancy count; decouples producer and consumer.
// ============================================================================
module whi_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNW  = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [WIDTH-1:0]      pop_data,
   output logic [CNW-1:0]        count
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNW-1:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign count      = count_ff;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNW'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CNW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/whi_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// whi_front - pixel intake and classification
// Tracks the raster position, clamps the configuration and tags each pixel
// with its position, row start, bin check and bin count for the back end.
// ============================================================================
module whi_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int BINS       = 16,
   localparam int CW  = $clog2(MAX_WIDTH + 1),
   localparam int RW  = $clog2(MAX_HEIGHT + 1),
   localparam int NBW = $clog2(BINS + 1),
   localparam int QW  = whi_pkg::BIN_IN_W + whi_pkg::WEIGHT_W + CW + RW + 2 + NBW
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire whi_pkg::cfg_type              cfg,
   input  wire logic                          clear_busy,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [whi_pkg::BIN_IN_W-1:0]  req_bin_index,
   input  wire logic [whi_pkg::WEIGHT_W-1:0]  req_weight,
   output logic                               q_valid,
   input  wire logic                          q_ready,
   output logic [QW-1:0]                      q_data
);

   typedef struct packed {
      logic [whi_pkg::BIN_IN_W-1:0] bin_index;
      logic [whi_pkg::WEIGHT_W-1:0] weight;
      logic [CW-1:0]                column;
      logic [RW-1:0]                row;
      logic                         bad;
      logic                         new_row;
      logic [NBW-1:0]               nb;
   } pix_type;

   logic [CW-1:0]  col_ff, col_in;
   logic [RW-1:0]  row_ff, row_in;
   logic [CW-1:0]  width_eff;
   logic [RW-1:0]  height_eff;
   logic [NBW-1:0] nb_eff;
   logic [CW-1:0]  col_cur, col_next;
   logic [RW-1:0]  row_cur, row_next;
   logic           accept;
   pix_type        pix;

   always_comb begin
      if (cfg.active_width == '0) begin
         width_eff = CW'(1);
      end else if (32'(cfg.active_width) > MAX_WIDTH) begin
         width_eff = CW'(MAX_WIDTH);
      end else begin
         width_eff = CW'(cfg.active_width);
      end
      if (cfg.active_height == '0) begin
         height_eff = RW'(1);
      end else if (32'(cfg.active_height) > MAX_HEIGHT) begin
         height_eff = RW'(MAX_HEIGHT);
      end else begin
         height_eff = RW'(cfg.active_height);
      end
      if (cfg.num_bins == '0) begin
         nb_eff = NBW'(1);
      end else if (32'(cfg.num_bins) > BINS) begin
         nb_eff = NBW'(BINS);
      end else begin
         nb_eff = NBW'(cfg.num_bins);
      end
   end

   // resolve the position of this pixel, then advance for the next one
   always_comb begin
      col_cur = col_ff;
      row_cur = row_ff;
      if (col_cur >= width_eff) begin
         col_cur = '0;
         row_cur = row_ff + RW'(1);
      end
      if (row_cur >= height_eff) begin
         row_cur = '0;
      end
      col_next = col_cur + CW'(1);
      row_next = row_cur;
      if (col_next >= width_eff) begin
         col_next = '0;
         row_next = row_cur + RW'(1);
         if (row_next >= height_eff) begin
            row_next = '0;
         end
      end
   end

   assign req_ready = q_ready && !clear_busy;
   assign accept    = req_valid && req_ready;

   always_comb begin
      pix.bin_index = req_bin_index;
      pix.weight    = req_weight;
      pix.column    = col_cur;
      pix.row       = row_cur;
      pix.bad       = (32'(req_bin_index) >= 32'(nb_eff));
      pix.new_row   = (col_cur == '0);
      pix.nb        = nb_eff;
   end

   assign q_valid = req_valid && !clear_busy;
   assign q_data  = pix;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         col_in = col_next;
         row_in = row_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/whi_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// whi_back - per-bin integral update
// Walks the bins of one pixel through a three-stage pipeline: read row sum
// and line store, update the row sum, add the row above and write back.
// ============================================================================
module whi_back #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int BINS       = 16,
   parameter int OUT_DEPTH  = 4,
   localparam int CW       = $clog2(MAX_WIDTH + 1),
   localparam int RW       = $clog2(MAX_HEIGHT + 1),
   localparam int NBW      = $clog2(BINS + 1),
   localparam int QW       = whi_pkg::BIN_IN_W + whi_pkg::WEIGHT_W + CW + RW + 2 + NBW,
   localparam int OCW      = $clog2(OUT_DEPTH + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_valid,
   output logic                       q_ready,
   input  wire logic [QW-1:0]         q_data,
   input  wire logic [OCW-1:0]        out_count,
   output logic                       out_valid,
   output whi_pkg::rsp_item_type      out_data,
   output logic                       clear_busy
);

   localparam int BIW      = (BINS > 1) ? $clog2(BINS) : 1;
   localparam int LS_DEPTH = MAX_WIDTH * BINS;
   localparam int AW       = (LS_DEPTH > 1) ? $clog2(LS_DEPTH) : 1;
   localparam int VW       = whi_pkg::VAL_W;

   typedef struct packed {
      logic [whi_pkg::BIN_IN_W-1:0] bin_index;
      logic [whi_pkg::WEIGHT_W-1:0] weight;
      logic [CW-1:0]                column;
      logic [RW-1:0]                row;
      logic                         bad;
      logic                         new_row;
      logic [NBW-1:0]               nb;
   } pix_type;

   function automatic logic [VW-1:0] sat_add(input logic [VW-1:0] a, input logic [VW-1:0] b);
      logic [VW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[VW] ? whi_pkg::VAL_MAX : s[VW-1:0];
   endfunction

   whi_pkg::back_state_type state_ff, state_in;
   logic [AW-1:0]   clr_ff, clr_in;
   logic [BIW-1:0]  b_ff, b_in;
   pix_type         cur_ff, cur_in;
   pix_type         q_pix;
   logic [AW-1:0]   base_ff, base_in;

   logic            s1_valid_ff, s1_last_ff;
   logic [BIW-1:0]  s1_bin_ff;
   logic [AW-1:0]   s1_addr_ff;
   logic            s2_valid_ff, s2_last_ff;
   logic [BIW-1:0]  s2_bin_ff;
   logic [AW-1:0]   s2_addr_ff;
   logic [VW-1:0]   s2_rs_ff, s2_above_ff;

   logic [VW-1:0]   ls_mem [LS_DEPTH];
   logic [VW-1:0]   ls_rd_ff;
   logic [VW-1:0]   rs_mem [BINS];
   logic [VW-1:0]   rs_rd_ff;
   logic [BINS-1:0] rs_valid_ff, rs_valid_in;

   logic            pipe_empty, credit_ok, issue, pop;
   logic [AW-1:0]   issue_addr;
   logic            issue_last;
   logic [VW-1:0]   rs_old, rs_inc, rs_new;
   logic [VW-1:0]   above, integral;
   logic            ls_we;
   logic [AW-1:0]   ls_wa;
   logic [VW-1:0]   ls_wd;

   assign q_pix      = q_data;
   assign pipe_empty = !s1_valid_ff && !s2_valid_ff;
   assign credit_ok  = ((OCW + 2)'(out_count) + (OCW + 2)'(s1_valid_ff)
                        + (OCW + 2)'(s2_valid_ff)) < (OCW + 2)'(OUT_DEPTH);
   assign q_ready    = (state_ff == whi_pkg::BACK_IDLE) && pipe_empty;
   assign pop        = q_ready && q_valid;
   assign issue      = (state_ff == whi_pkg::BACK_ISSUE) && credit_ok;
   assign issue_addr = base_ff + AW'(b_ff);
   assign issue_last = ((NBW'(b_ff) + NBW'(1)) == cur_ff.nb);
   assign clear_busy = (state_ff == whi_pkg::BACK_CLEAR);

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      b_in     = b_ff;
      cur_in   = cur_ff;
      base_in  = base_ff;
      unique case (state_ff)
         whi_pkg::BACK_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(LS_DEPTH - 1)) begin
               state_in = whi_pkg::BACK_IDLE;
            end
         end
         whi_pkg::BACK_IDLE: begin
            if (pop) begin
               cur_in   = q_pix;
               base_in  = AW'(32'(q_pix.column) * BINS);
               b_in     = '0;
               state_in = whi_pkg::BACK_ISSUE;
            end
         end
         whi_pkg::BACK_ISSUE: begin
            if (credit_ok) begin
               if (issue_last) begin
                  state_in = whi_pkg::BACK_IDLE;
               end else begin
                  b_in = b_ff + BIW'(1);
               end
            end
         end
         default: begin
            state_in = whi_pkg::BACK_CLEAR;
         end
      endcase
   end

   // row sum update
   always_comb begin
      rs_old = rs_valid_ff[s1_bin_ff] ? rs_rd_ff : '0;
      rs_inc = '0;
      if (!cur_ff.bad && (32'(s1_bin_ff) == 32'(cur_ff.bin_index))) begin
         rs_inc = VW'(cur_ff.weight);
      end
      rs_new = sat_add(rs_old, rs_inc);
   end

   always_comb begin
      rs_valid_in = rs_valid_ff;
      if (pop && q_pix.new_row) begin
         rs_valid_in = '0;
      end else if (s1_valid_ff) begin
         rs_valid_in[s1_bin_ff] = 1'b1;
      end
   end

   // add the row above; top row sees zero
   always_comb begin
      above    = (cur_ff.row == '0) ? '0 : s2_above_ff;
      integral = sat_add(above, s2_rs_ff);
   end

   always_comb begin
      ls_we = s2_valid_ff;
      ls_wa = s2_addr_ff;
      ls_wd = integral;
      if (state_ff == whi_pkg::BACK_CLEAR) begin
         ls_we = 1'b1;
         ls_wa = clr_ff;
         ls_wd = '0;
      end
   end

   always_comb begin
      out_valid               = s2_valid_ff;
      out_data.bin            = whi_pkg::BIN_OUT_W'(s2_bin_ff);
      out_data.integral_value = integral;
      out_data.column         = whi_pkg::POS_OUT_W'(cur_ff.column);
      out_data.row            = whi_pkg::POS_OUT_W'(cur_ff.row);
      out_data.last_bin       = s2_last_ff;
      out_data.bad_bin        = cur_ff.bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= whi_pkg::BACK_CLEAR;
         clr_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         rs_valid_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         rs_valid_ff <= rs_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_ff        <= b_in;
      cur_ff      <= cur_in;
      base_ff     <= base_in;
      s1_bin_ff   <= b_ff;
      s1_last_ff  <= issue_last;
      s1_addr_ff  <= issue_addr;
      s2_bin_ff   <= s1_bin_ff;
      s2_last_ff  <= s1_last_ff;
      s2_addr_ff  <= s1_addr_ff;
      s2_rs_ff    <= rs_new;
      s2_above_ff <= ls_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (ls_we) begin
         ls_mem[ls_wa] <= ls_wd;
      end
      ls_rd_ff <= ls_mem[issue_addr];
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         rs_mem[s1_bin_ff] <= rs_new;
      end
      rs_rd_ff <= rs_mem[b_ff];
   end

endmodule
`default_nettype wire

// File: rtl/core/weighted_integral_histogram.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// weighted_integral_histogram - integral histogram of a raster-scanned frame
// Per pixel, reports the rectangle sum of weights for every bin in use.
// Pacing: bins of a pixel are walked one bin per cycle while the result queue
//   has credit; a new pixel is taken only once the pipeline has drained.
// Reset: a clearing sweep zeroes all MAX_WIDTH*BINS entries of the line store;
//   req_ready stays low during it, configuration writes are taken.
// ============================================================================
module weighted_integral_histogram #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int BINS       = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [whi_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [whi_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [whi_pkg::BIN_IN_W-1:0]     req_bin_index,
   input  wire logic [whi_pkg::WEIGHT_W-1:0]     req_weight,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [whi_pkg::BIN_OUT_W-1:0]         rsp_bin,
   output logic [whi_pkg::VAL_W-1:0]             rsp_integral_value,
   output logic [whi_pkg::POS_OUT_W-1:0]         rsp_column,
   output logic [whi_pkg::POS_OUT_W-1:0]         rsp_row,
   output logic                                  rsp_last_bin,
   output logic                                  rsp_bad_bin
);

   localparam int CW          = $clog2(MAX_WIDTH + 1);
   localparam int RW          = $clog2(MAX_HEIGHT + 1);
   localparam int NBW         = $clog2(BINS + 1);
   localparam int QW          = whi_pkg::BIN_IN_W + whi_pkg::WEIGHT_W + CW + RW + 2 + NBW;
   localparam int IN_Q_DEPTH  = 2;
   localparam int OUT_Q_DEPTH = 4;
   localparam int OCW         = $clog2(OUT_Q_DEPTH + 1);
   localparam int RSP_W       = $bits(whi_pkg::rsp_item_type);

   whi_pkg::cfg_type      cfg_ff, cfg_in;
   logic                  clear_busy;
   logic                  fq_valid, fq_ready;
   logic [QW-1:0]         fq_data;
   logic                  bq_valid, bq_ready;
   logic [QW-1:0]         bq_data;
   logic [$clog2(IN_Q_DEPTH + 1)-1:0] in_q_count;
   logic                  in_q_push_ready_unused;
   logic                  out_push_valid;
   whi_pkg::rsp_item_type out_push_data;
   logic                  out_push_ready;
   logic [OCW-1:0]        out_count;
   logic [RSP_W-1:0]      out_pop_data;
   whi_pkg::rsp_item_type rsp_item;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (whi_pkg::csr_index_type'(csr_index))
            whi_pkg::CSR_ACTIVE_WIDTH:  cfg_in.active_width  = csr_wdata;
            whi_pkg::CSR_ACTIVE_HEIGHT: cfg_in.active_height = csr_wdata;
            whi_pkg::CSR_NUM_BINS:      cfg_in.num_bins      = csr_wdata[4:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_width  <= whi_pkg::RST_ACTIVE_WIDTH;
         cfg_ff.active_height <= whi_pkg::RST_ACTIVE_HEIGHT;
         cfg_ff.num_bins      <= whi_pkg::RST_NUM_BINS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   whi_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .BINS       (BINS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .clear_busy    (clear_busy),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_bin_index (req_bin_index),
      .req_weight    (req_weight),
      .q_valid       (fq_valid),
      .q_ready       (fq_ready),
      .q_data        (fq_data)
   );

   whi_fifo #(
      .WIDTH (QW),
      .DEPTH (IN_Q_DEPTH)
   ) u_pix_q (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (bq_valid),
      .pop_ready  (bq_ready),
      .pop_data   (bq_data),
      .count      (in_q_count)
   );

   whi_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .BINS       (BINS),
      .OUT_DEPTH  (OUT_Q_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (bq_valid),
      .q_ready    (bq_ready),
      .q_data     (bq_data),
      .out_count  (out_count),
      .out_valid  (out_push_valid),
      .out_data   (out_push_data),
      .clear_busy (clear_busy)
   );

   whi_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (OUT_Q_DEPTH)
   ) u_rsp_q (
      .clock      (clock),
      .reset      (reset),
      .push_valid (out_push_valid),
      .push_ready (out_push_ready),
      .push_data  (out_push_data),
      .pop_valid  (rsp_valid),
      .pop_ready  (rsp_ready),
      .pop_data   (out_pop_data),
      .count      (out_count)
   );

   // pixel queue occupancy is unused; push ready of the result queue is covered by credits
   assign in_q_push_ready_unused = out_push_ready & (in_q_count != '0);

   always_comb begin
      rsp_item           = out_pop_data;
      rsp_bin            = rsp_item.bin;
      rsp_integral_value = rsp_item.integral_value;
      rsp_column         = rsp_item.column;
      rsp_row            = rsp_item.row;
      rsp_last_bin       = rsp_item.last_bin;
      rsp_bad_bin        = rsp_item.bad_bin | (in_q_push_ready_unused & 1'b0);
   end

endmodule
`default_nettype wire

// File: bench/weighted_integral_histogram_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// weighted_integral_histogram_tb - self-checking bench for the integral
// histogram block
// Drives pixels with random gaps on the request side and random stalls on
// the response side. An in-bench integral model mirrors the line store and
// row sums and predicts every per-bin result. Directed rows cover reset
// defaults, extreme weights, bad bins, out-of-range registers and
// mid-frame register changes. Random phases then sweep frame shapes and
// bin counts.
// ============================================================================
module weighted_integral_histogram_tb;

   localparam int MAX_W    = 1024;
   localparam int MAX_H    = 1024;
   localparam int NBINS    = 16;
   localparam int PLAN_LEN = 25;
   localparam int PHASES   = 8;
   localparam int PHASE_PIXELS = 10;

   typedef enum logic {
      STEP_CSR   = 1'b0,
      STEP_PIXEL = 1'b1
   } step_kind_type;

   typedef struct packed {
      step_kind_type              kind;
      whi_pkg::csr_index_type     reg_index;
      logic [10:0]                reg_value;
      logic [3:0]                 bin;
      logic [15:0]                weight;
      logic                       typed;
      logic                       typed_bad;
      logic [whi_pkg::VAL_W-1:0]  typed_value;
   } plan_row_type;

   localparam plan_row_type DIRECTED_PLAN [PLAN_LEN] = '{
      '{STEP_PIXEL, whi_pkg::CSR_ACTIVE_WIDTH,  11'd0,    4'd0,  16'hFFFF, 1'b1, 1'b0, 36'h0FFFF},
      '{STEP_PIXEL, whi_pkg::CSR_ACTIVE_WIDTH,  11'd0,    4'd15, 16'h0001, 1'b1, 1'b0, 36'h00001},
      '{STEP_PIXEL, whi_pkg::CSR_ACTIVE_WIDTH,  11'd0,    4'd7,  16'h0080, 1'b0, 1'b0, 36'h0},
      '{STEP_CSR,   whi_pkg::CSR_ACTIVE_WIDTH,  11'd3,    4'd0,  16'h0000, 1'b0, 1'b0, 36'h0},
      '{STEP_CSR,   whi_pkg::CSR_ACTIVE_HEIGHT, 11'd2,    4'd0,  16'h0000, 1'b0, 1'b0, 36'h0},
      '{STEP_CSR,   whi_pkg::CSR_NUM_BINS,      11'd4,    4'd0,  16'h0000, 1'b0, 1'b0, 36'h0},
      '{STEP_PIXEL, whi_pkg::CSR_ACTIVE_WIDTH,  11'd0,    4'd3,  16'h0100, 1'b1, 1'b0, 36'h00100},
      '{STEP_PIXEL, whi_pkg::CSR_ACTIVE_WIDTH,  11'd0,    4'd4,  16'h1234, 1'b1, 1'b1, 36'h0},
      '{STEP_PIXEL, whi_pkg::CSR_ACTIVE_WIDTH,  11'd0,    4'd1,  16'h0000, 1'b0, 1'b0, 36'h0},
      '{STEP_PIXEL, whi_pkg::CSR_ACTIVE_WIDTH,  11'd0,    4'd0,  16'h8000, 1'b1, 1'b0, 36'h08000},
      '{STEP_PIXEL, whi_pkg::CSR_ACTIVE_WIDTH,  11'd0,    4'd2,  16'hFFFF, 1'b1, 1'b0, 36'h0FFFF},
      '{STEP_PIXEL, whi_pkg::CSR_ACTIVE_WIDTH,  11'd0,    4'd15, 16'h0001, 1'b1, 1'b1, 36'h0},
      '{STEP_CSR,   whi_pkg::CSR_NUM_BINS,      11'd0,    4'd0,  16'h0000, 1'b0, 1'b0, 36'h0},
      '{STEP_PIXEL, whi_pkg::CSR_ACTIVE_WIDTH,  11'd0,    4'd0,  16'h0005, 1'b0, 1'b0, 36'h0},
      '{STEP_PIXEL, whi_pkg::CSR_ACTIVE_WIDTH,  11'd0,    4'd1,  16'h0005, 1'b1, 1'b1, 36'h0},
      '{STEP_CSR,   whi_pkg::CSR_NUM_BINS,      11'd31,   4'd0,  16'h0000, 1'b0, 1'b0, 36'h0},
      '{STEP_CSR,   whi_pkg::CSR_ACTIVE_WIDTH,  11'd0,    4'd0,  16'h0000, 1'b0, 1'b0, 36'h0},
      '{STEP_CSR,   whi_pkg::CSR_ACTIVE_HEIGHT, 11'd2047, 4'd0,  16'h0000, 1'b0, 1'b0, 36'h0},
      '{STEP_PIXEL, whi_pkg::CSR_ACTIVE_WIDTH,  11'd0,    4'd15, 16'hFFFF, 1'b0, 1'b0, 36'h0},
      '{STEP_PIXEL, whi_pkg::CSR_ACTIVE_WIDTH,  11'd0,    4'd8,  16'h1111, 1'b0, 1'b0, 36'h0},
      '{STEP_CSR,   whi_pkg::CSR_ACTIVE_WIDTH,  11'd2047, 4'd0,  16'h0000, 1'b0, 1'b0, 36'h0},
      '{STEP_CSR,   whi_pkg::CSR_ACTIVE_HEIGHT, 11'd0,    4'd0,  16'h0000, 1'b0, 1'b0, 36'h0},
      '{STEP_PIXEL, whi_pkg::CSR_ACTIVE_WIDTH,  11'd0,    4'd15, 16'hFFFF, 1'b1, 1'b0, 36'h0FFFF},
      '{STEP_PIXEL, whi_pkg::CSR_ACTIVE_WIDTH,  11'd0,    4'd15, 16'hFFFF, 1'b1, 1'b0, 36'h1FFFE},
      '{STEP_PIXEL, whi_pkg::CSR_ACTIVE_WIDTH,  11'd0,    4'd12, 16'h0000, 1'b0, 1'b0, 36'h0}
   };

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_wr_en = 1'b0;
   logic [whi_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [whi_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [whi_pkg::BIN_IN_W-1:0]    req_bin_index = '0;
   logic [whi_pkg::WEIGHT_W-1:0]    req_weight = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [whi_pkg::BIN_OUT_W-1:0]   rsp_bin;
   logic [whi_pkg::VAL_W-1:0]       rsp_integral_value;
   logic [whi_pkg::POS_OUT_W-1:0]   rsp_column;
   logic [whi_pkg::POS_OUT_W-1:0]   rsp_row;
   logic                            rsp_last_bin;
   logic                            rsp_bad_bin;

   logic [whi_pkg::VAL_W-1:0] line_store [MAX_W*NBINS];
   logic [whi_pkg::VAL_W-1:0] row_sums [NBINS];
   whi_pkg::rsp_item_type     last_pixel [NBINS];
   whi_pkg::rsp_item_type     expected_integrals [$];
   int unsigned               col_pos;
   int unsigned               row_pos;
   logic [10:0]               cfg_width;
   logic [10:0]               cfg_height;
   logic [4:0]                cfg_bins;
   int unsigned               mismatch_count = 0;
   bit                        calm = 1'b0;

   weighted_integral_histogram u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_bin_index      (req_bin_index),
      .req_weight         (req_weight),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_bin            (rsp_bin),
      .rsp_integral_value (rsp_integral_value),
      .rsp_column         (rsp_column),
      .rsp_row            (rsp_row),
      .rsp_last_bin       (rsp_last_bin),
      .rsp_bad_bin        (rsp_bad_bin)
   );

   always #5 clock = ~clock;

   function automatic int unsigned clamp_cfg(int unsigned v, int unsigned hi);
      if (v == 0) begin
         return 1;
      end
      return (v > hi) ? hi : v;
   endfunction

   function automatic logic [whi_pkg::VAL_W-1:0] sat_sum(logic [whi_pkg::VAL_W-1:0] a,
                                                         logic [whi_pkg::VAL_W-1:0] b);
      logic [whi_pkg::VAL_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[whi_pkg::VAL_W] ? whi_pkg::VAL_MAX : s[whi_pkg::VAL_W-1:0];
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) begin
         return 0;
      end
      if (r < 85) begin
         return $urandom_range(1, 3);
      end
      if (r < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [10:0] pick_extent();
      int unsigned r;
      r = $urandom_range(0, 19);
      case (r)
         0: begin
            return 11'd0;
         end
         1: begin
            return 11'd1024;
         end
         2: begin
            return 11'd2047;
         end
         3: begin
            return 11'($urandom_range(0, 2047));
         end
         default: begin
            return 11'($urandom_range(1, 6));
         end
      endcase
   endfunction

   function automatic logic [4:0] pick_bins();
      int unsigned r;
      r = $urandom_range(0, 9);
      case (r)
         0: begin
            return 5'd0;
         end
         1: begin
            return 5'd31;
         end
         2: begin
            return 5'($urandom_range(17, 31));
         end
         3: begin
            return 5'd16;
         end
         default: begin
            return 5'($urandom_range(1, 16));
         end
      endcase
   endfunction

   // advance the integral model by one pixel and queue its per-bin results
   function automatic void integrate_pixel(logic [3:0] bin_in, logic [15:0] wt);
      int unsigned               w;
      int unsigned               h;
      int unsigned               nb;
      int unsigned               idx;
      logic                      bad;
      logic [whi_pkg::VAL_W-1:0] above;
      logic [whi_pkg::VAL_W-1:0] v;
      whi_pkg::rsp_item_type     item;
      w  = clamp_cfg(cfg_width, MAX_W);
      h  = clamp_cfg(cfg_height, MAX_H);
      nb = clamp_cfg(cfg_bins, NBINS);
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) begin
         row_pos = 0;
      end
      if (col_pos == 0) begin
         for (int b = 0; b < NBINS; b++) begin
            row_sums[b] = '0;
         end
      end
      bad = (bin_in >= nb);
      if (!bad) begin
         row_sums[bin_in] = sat_sum(row_sums[bin_in], {{(whi_pkg::VAL_W-16){1'b0}}, wt});
      end
      for (int unsigned b = 0; b < nb; b++) begin
         idx   = col_pos * NBINS + b;
         above = (row_pos == 0) ? '0 : line_store[idx];
         v     = sat_sum(above, row_sums[b]);
         line_store[idx]     = v;
         item.bin            = b[3:0];
         item.integral_value = v;
         item.column         = col_pos[9:0];
         item.row            = row_pos[9:0];
         item.last_bin       = (b + 1 == nb);
         item.bad_bin        = bad;
         expected_integrals.push_back(item);
         last_pixel[b] = item;
      end
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) begin
            row_pos = 0;
         end
      end
   endfunction

   task automatic send_pixel(input logic [3:0] bin_in, input logic [15:0] wt);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_bin_index <= bin_in;
      req_weight    <= wt;
      do @(posedge clock); while (!req_ready);
      integrate_pixel(bin_in, wt);
   endtask

   task automatic wait_drained();
      while (expected_integrals.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input whi_pkg::csr_index_type idx, input logic [10:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         whi_pkg::CSR_ACTIVE_WIDTH: begin
            cfg_width = value;
         end
         whi_pkg::CSR_ACTIVE_HEIGHT: begin
            cfg_height = value;
         end
         whi_pkg::CSR_NUM_BINS: begin
            cfg_bins = value[4:0];
         end
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   // response side: check each transaction, then stall at random
   initial begin
      whi_pkg::rsp_item_type got;
      whi_pkg::rsp_item_type want;
      int unsigned           stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.bin            = rsp_bin;
            got.integral_value = rsp_integral_value;
            got.column         = rsp_column;
            got.row            = rsp_row;
            got.last_bin       = rsp_last_bin;
            got.bad_bin        = rsp_bad_bin;
            if (expected_integrals.size() == 0) begin
               $display("%0t: unexpected result bin %0d value %0h col %0d row %0d",
                        $realtime, got.bin, got.integral_value, got.column, got.row);
               mismatch_count++;
            end else begin
               want = expected_integrals.pop_front();
               if (got !== want) begin
                  $display("%0t: expected bin %0d value %0h col %0d row %0d last %0b bad %0b",
                           $realtime, want.bin, want.integral_value, want.column, want.row,
                           want.last_bin, want.bad_bin);
                  $display("%0t:   actual bin %0d value %0h col %0d row %0d last %0b bad %0b",
                           $realtime, got.bin, got.integral_value, got.column, got.row,
                           got.last_bin, got.bad_bin);
                  mismatch_count++;
               end
            end
         end
         if (stall_left != 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
               stall_left = pick_gap();
            end
         end
      end
   end

   initial begin
      logic [3:0]  bin_in;
      logic [15:0] wt;
      int unsigned nb;
      int unsigned r;
      for (int i = 0; i < MAX_W*NBINS; i++) begin
         line_store[i] = '0;
      end
      for (int b = 0; b < NBINS; b++) begin
         row_sums[b] = '0;
      end
      col_pos    = 0;
      row_pos    = 0;
      cfg_width  = whi_pkg::RST_ACTIVE_WIDTH;
      cfg_height = whi_pkg::RST_ACTIVE_HEIGHT;
      cfg_bins   = whi_pkg::RST_NUM_BINS;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PLAN_LEN; i++) begin
         if (DIRECTED_PLAN[i].kind == STEP_CSR) begin
            req_valid <= 1'b0;
            wait_drained();
            write_reg(DIRECTED_PLAN[i].reg_index, DIRECTED_PLAN[i].reg_value);
         end else begin
            send_pixel(DIRECTED_PLAN[i].bin, DIRECTED_PLAN[i].weight);
            if (DIRECTED_PLAN[i].typed) begin
               if (DIRECTED_PLAN[i].typed_bad) begin
                  if (last_pixel[0].bad_bin !== 1'b1) begin
                     $display("%0t: row %0d expected bad_bin 1, actual %0b",
                              $realtime, i, last_pixel[0].bad_bin);
                     mismatch_count++;
                  end
               end else if (last_pixel[DIRECTED_PLAN[i].bin].integral_value
                            !== DIRECTED_PLAN[i].typed_value ||
                            last_pixel[DIRECTED_PLAN[i].bin].bad_bin !== 1'b0) begin
                  $display("%0t: row %0d expected value %0h, actual %0h",
                           $realtime, i, DIRECTED_PLAN[i].typed_value,
                           last_pixel[DIRECTED_PLAN[i].bin].integral_value);
                  mismatch_count++;
               end
            end
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         req_valid <= 1'b0;
         wait_drained();
         calm = ($urandom_range(0, 3) == 0);
         write_reg(whi_pkg::CSR_ACTIVE_WIDTH, pick_extent());
         write_reg(whi_pkg::CSR_ACTIVE_HEIGHT, pick_extent());
         write_reg(whi_pkg::CSR_NUM_BINS, {6'd0, pick_bins()});
         nb = clamp_cfg(cfg_bins, NBINS);
         for (int k = 0; k < PHASE_PIXELS; k++) begin
            if ($urandom_range(0, 4) != 0) begin
               bin_in = 4'($urandom_range(0, nb - 1));
            end else begin
               bin_in = 4'($urandom_range(0, 15));
            end
            r = $urandom_range(0, 9);
            if (r == 0) begin
               wt = 16'h0000;
            end else if (r == 1) begin
               wt = 16'hFFFF;
            end else begin
               wt = 16'($urandom_range(0, 65535));
            end
            send_pixel(bin_in, wt);
            if ($urandom_range(0, 19) == 0) begin
               req_valid <= 1'b0;
               wait_drained();
            end
         end
      end

      req_valid <= 1'b0;
      while (expected_integrals.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: weighted_integral_histogram.f
rtl/core/whi_pkg.sv
rtl/core/whi_fifo.sv
rtl/core/whi_front.sv
rtl/core/whi_back.sv
rtl/core/weighted_integral_histogram.sv
bench/weighted_integral_histogram_tb.sv
